// ----- design/wsrq_pkg.sv -----
// ----------------------------------------------------------------------------
// wsrq_pkg
// Types and codes shared by the sequence reorder queue modules.
// ----------------------------------------------------------------------------
package wsrq_pkg;

  localparam int SEQ_W = 7;
  localparam int WIN_W = 7;
  localparam int TOTAL_W = 8;
  localparam logic [WIN_W-1:0] WINDOW_RESET = 7'd64;

  typedef logic [SEQ_W-1:0] seq_t;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_PEEK   = 2'd1,
    MODE_POP    = 2'd2,
    MODE_NOP    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_FULL  = 2'd1,
    ERR_RANGE = 2'd2,
    ERR_RSVD  = 2'd3
  } err_t;

  // broadcast controls for one row of cells
  typedef struct packed {
    logic ins;
    logic pop;
  } cell_ctl_t;

  typedef struct packed {
    logic ins;
    logic pop;
    seq_t seq;
  } ring_cmd_t;

  typedef struct packed {
    seq_t head;
    seq_t top;
    logic empty;
    logic full;
  } ring_stat_t;

endpackage

// ----- design/wsrq_cell.sv -----
// ----------------------------------------------------------------------------
// wsrq_cell
// One slot of a sorted shift row: holds an entry, shifts right on insert
// and left on pop.
// ----------------------------------------------------------------------------
module wsrq_cell import wsrq_pkg::*; (
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  logic      occ,
  input  seq_t      ins_val,
  input  seq_t      left_val,
  input  logic      left_gt,
  input  seq_t      right_val,
  output seq_t      val,
  output logic      gt
);

  assign gt = occ && (val > ins_val);

  always_ff @(posedge clk) begin
    if (ctl.pop) begin
      val <= right_val;
    end else if (ctl.ins) begin
      // left neighbor larger: make room by taking its entry
      if (left_gt) begin
        val <= left_val;
      end else if (gt || !occ) begin
        val <= ins_val;
      end
    end
  end

endmodule

// ----- design/wsrq_ring.sv -----
// ----------------------------------------------------------------------------
// wsrq_ring
// Sorted ring of entries built as a row of cells, with fill count and
// a register tracking the largest entry.
// ----------------------------------------------------------------------------
module wsrq_ring import wsrq_pkg::*; #(
  parameter int RING_DEPTH = 64,
  parameter int CW = $clog2(RING_DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  ring_cmd_t     cmd,
  output ring_stat_t    stat,
  output logic [CW-1:0] count
);

  seq_t      vals [RING_DEPTH];
  logic      gts  [RING_DEPTH];
  seq_t      top;
  cell_ctl_t ctl;
  logic      empty;
  logic      full;

  assign empty = (count == '0);
  assign full  = (count == CW'(RING_DEPTH));

  assign ctl.ins = cmd.ins && !full;
  assign ctl.pop = cmd.pop && !empty;

  for (genvar i = 0; i < RING_DEPTH; i++) begin : g_cell
    wsrq_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .occ       (CW'(i) < count),
      .ins_val   (cmd.seq),
      .left_val  ((i == 0) ? cmd.seq : vals[(i == 0) ? 0 : i - 1]),
      .left_gt   ((i == 0) ? 1'b0 : gts[(i == 0) ? 0 : i - 1]),
      .right_val (vals[(i == RING_DEPTH - 1) ? i : i + 1]),
      .val       (vals[i]),
      .gt        (gts[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.ins) begin
      count <= count + CW'(1);
    end else if (ctl.pop) begin
      count <= count - CW'(1);
    end
  end

  // largest entry changes only on insert (any insert into an empty ring sets it); pops never update it
  always_ff @(posedge clk) begin
    if (ctl.ins && (empty || (cmd.seq > top))) begin
      top <= cmd.seq;
    end
  end

  assign stat.head  = vals[0];
  assign stat.top   = top;
  assign stat.empty = empty;
  assign stat.full  = full;

endmodule

// ----- design/wrapping_sequence_reorder_queue_core.sv -----
// ----------------------------------------------------------------------------
// wrapping_sequence_reorder_queue_core
// Timing: the result is registered; one request per cycle
// while the result side keeps up (the row of cells updates together with the result register).
// Reset: both rings empty, ring zero first, window 64; cell contents undefined.
// Two sorted cell rows hold cyclic sequence numbers split by window.
// ----------------------------------------------------------------------------
module wrapping_sequence_reorder_queue_core import wsrq_pkg::*; #(
  parameter int MAX_WINDOW = 64,
  parameter int RING_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [WIN_W-1:0]   cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         mode,
  input  logic [SEQ_W-1:0]   seq_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [SEQ_W-1:0]   seq_out,
  output logic               is_empty,
  output logic [TOTAL_W-1:0] total_count,
  output logic [1:0]         error_code
);

  localparam int CW = $clog2(RING_DEPTH + 1);
  localparam int WMW = $clog2(MAX_WINDOW + 1);
  localparam int WW = (WMW > WIN_W) ? WMW : WIN_W;
  localparam int SW = (CW + 1 > TOTAL_W) ? CW + 1 : TOTAL_W;

  logic [WIN_W-1:0] window_size;
  logic             sel;
  logic             sel_next;
  logic             acc;

  ring_cmd_t        cmd0, cmd1;
  ring_stat_t       st0, st1;
  logic [CW-1:0]    cnt0, cnt1;

  ring_stat_t       st_first, st_second;
  logic [CW-1:0]    cnt_first, cnt_second;
  logic [WW-1:0]    win;
  seq_t             diff;
  logic             to_second;
  logic             ins_ok;
  logic             pop_ok;
  logic             ins_first, ins_second;
  mode_t            op;
  seq_t             seq_res;
  logic             empty_res;
  err_t             err_res;
  logic [SW-1:0]    total_res;

  assign in_ready = !out_valid || out_ready;
  assign acc      = in_valid && in_ready;
  assign op       = mode_t'(mode);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WINDOW_RESET;
    end else if (cfg_wr_en) begin
      window_size <= cfg_wr_data;
    end
  end

  assign st_first   = sel ? st1 : st0;
  assign st_second  = sel ? st0 : st1;
  assign cnt_first  = sel ? cnt1 : cnt0;
  assign cnt_second = sel ? cnt0 : cnt1;

  always_comb begin
    win = (WW'(window_size) > WW'(MAX_WINDOW)) ? WW'(MAX_WINDOW) : WW'(window_size);
    diff = (seq_in > st_first.top) ? seq_in - st_first.top : st_first.top - seq_in;
    to_second = !st_first.empty && (WW'(diff) >= win);
    seq_res = '0;
    empty_res = 1'b0;
    err_res = ERR_OK;
    ins_first = 1'b0;
    ins_second = 1'b0;
    pop_ok = 1'b0;
    case (op)
      MODE_INSERT: begin
        if ({1'b0, WW'(seq_in)} >= {win, 1'b0}) begin
          err_res = ERR_RANGE;
        end else if (to_second ? st_second.full : st_first.full) begin
          err_res = ERR_FULL;
        end else begin
          ins_first = !to_second;
          ins_second = to_second;
        end
      end
      MODE_PEEK, MODE_POP: begin
        if (st_first.empty) begin
          empty_res = 1'b1;
        end else begin
          seq_res = st_first.head;
          pop_ok = (op == MODE_POP);
        end
      end
      default: begin
      end
    endcase
    ins_ok = ins_first || ins_second;
    total_res = SW'(cnt0) + SW'(cnt1) + SW'(ins_ok) - SW'(pop_ok);
    // the first ring emptying hands its role to the other ring
    sel_next = (pop_ok && (cnt_first == CW'(1))) ? !sel : sel;
  end

  always_comb begin
    cmd0.seq = seq_in;
    cmd1.seq = seq_in;
    cmd0.ins = acc && (sel ? ins_second : ins_first);
    cmd1.ins = acc && (sel ? ins_first : ins_second);
    cmd0.pop = acc && pop_ok && !sel;
    cmd1.pop = acc && pop_ok && sel;
  end

  wsrq_ring #(.RING_DEPTH(RING_DEPTH), .CW(CW)) u_ring0 (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd0),
    .stat  (st0),
    .count (cnt0)
  );

  wsrq_ring #(.RING_DEPTH(RING_DEPTH), .CW(CW)) u_ring1 (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd1),
    .stat  (st1),
    .count (cnt1)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sel <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (acc) begin
        sel <= sel_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      seq_out <= seq_res;
      is_empty <= empty_res;
      total_count <= total_res[TOTAL_W-1:0];
      error_code <= err_res;
    end
  end

  a_second_needs_first: assert property (@(posedge clk) disable iff (rst)
    (cnt_first == '0) |-> (cnt_second == '0))
    else $error("second ring holds entries while first ring is empty");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (cnt0 <= CW'(RING_DEPTH)) && (cnt1 <= CW'(RING_DEPTH)))
    else $error("ring count beyond depth");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && is_empty) |-> ((seq_out == '0) && (error_code == ERR_OK)))
    else $error("empty result carries a value or error");

  a_swap_on_drain: assert property (@(posedge clk) disable iff (rst)
    (acc && (op == MODE_POP) && (cnt_first == CW'(1))) |=> (sel != $past(sel)))
    else $error("rings did not swap after first ring drained");

endmodule
